### rtl/sdc_pkg.sv
package sdc_pkg;

   localparam int CoordW    = 32;
   localparam int DiffW     = CoordW + 1;
   localparam int ProdW     = 2 * DiffW;
   localparam int SumW      = ProdW + 1;
   localparam int MagW      = ProdW;
   localparam int HalfW     = MagW / 2;
   localparam int NW        = 2 * MagW - 1;
   localparam int CandW     = NW + 1;
   localparam int MW        = MagW;
   localparam int DistW     = 32;
   localparam int QW        = MW + DistW;
   localparam int RootSteps = DistW;
   localparam int CfgIdxW   = 2;

   typedef enum logic [CfgIdxW-1:0] {
      CFG_START_X = 2'd0,
      CFG_START_Y = 2'd1,
      CFG_END_X   = 2'd2,
      CFG_END_Y   = 2'd3
   } cfg_index_type;

   typedef enum logic {
      OP_DISTANCE = 1'b0,
      OP_CROSSING = 1'b1
   } op_type;

   typedef struct packed {
      op_type                op;
      logic signed [SumW-1:0] dot;
      logic [MW-1:0]          len2;
      logic [MagW-1:0]        norm_start;
      logic [MagW-1:0]        norm_end;
      logic signed [SumW-1:0] un;
      logic signed [SumW-1:0] den;
      logic signed [SumW-1:0] tn;
   } front_out_type;

   typedef struct packed {
      op_type        op;
      logic          hit;
      logic [NW-1:0] n;
      logic [MW-1:0] m;
   } root_in_type;

   function automatic logic signed [DiffW-1:0] sdiff(input logic [CoordW-1:0] a,
                                                     input logic [CoordW-1:0] b);
      sdiff = $signed({a[CoordW-1], a}) - $signed({b[CoordW-1], b});
   endfunction

endpackage

### rtl/sdc_front.sv
module sdc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  sdc_pkg::op_type               in_op,
   input  logic [sdc_pkg::CoordW-1:0]    a_x,
   input  logic [sdc_pkg::CoordW-1:0]    a_y,
   input  logic [sdc_pkg::CoordW-1:0]    b_x,
   input  logic [sdc_pkg::CoordW-1:0]    b_y,
   input  logic [sdc_pkg::CoordW-1:0]    s_x,
   input  logic [sdc_pkg::CoordW-1:0]    s_y,
   input  logic [sdc_pkg::CoordW-1:0]    e_x,
   input  logic [sdc_pkg::CoordW-1:0]    e_y,
   output logic                          out_valid,
   output sdc_pkg::front_out_type        out_data
);

   // stage 1: differences
   logic v1_ff;
   sdc_pkg::op_type op1_ff;
   logic signed [sdc_pkg::DiffW-1:0] dx1_ff, dy1_ff, wx1_ff, wy1_ff;
   logic signed [sdc_pkg::DiffW-1:0] ux1_ff, uy1_ff, qx1_ff, qy1_ff;

   // stage 2: products
   logic v2_ff;
   sdc_pkg::op_type op2_ff;
   logic signed [sdc_pkg::ProdW-1:0] p_wd_ff, p_wd2_ff, p_dx2_ff, p_dy2_ff;
   logic signed [sdc_pkg::ProdW-1:0] p_wx2_ff, p_wy2_ff, p_ux2_ff, p_uy2_ff;
   logic signed [sdc_pkg::ProdW-1:0] p_wxdy_ff, p_wydx_ff, p_dxqy_ff, p_dyqx_ff;
   logic signed [sdc_pkg::ProdW-1:0] p_wxqy_ff, p_wyqx_ff;

   // stage 3: sums
   logic v3_ff;
   sdc_pkg::front_out_type f3_in, f3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op1_ff <= in_op;
         dx1_ff <= sdc_pkg::sdiff(e_x, s_x);
         dy1_ff <= sdc_pkg::sdiff(e_y, s_y);
         wx1_ff <= sdc_pkg::sdiff(a_x, s_x);
         wy1_ff <= sdc_pkg::sdiff(a_y, s_y);
         ux1_ff <= sdc_pkg::sdiff(a_x, e_x);
         uy1_ff <= sdc_pkg::sdiff(a_y, e_y);
         qx1_ff <= sdc_pkg::sdiff(b_x, a_x);
         qy1_ff <= sdc_pkg::sdiff(b_y, a_y);

         op2_ff    <= op1_ff;
         p_wd_ff   <= wx1_ff * dx1_ff;
         p_wd2_ff  <= wy1_ff * dy1_ff;
         p_dx2_ff  <= dx1_ff * dx1_ff;
         p_dy2_ff  <= dy1_ff * dy1_ff;
         p_wx2_ff  <= wx1_ff * wx1_ff;
         p_wy2_ff  <= wy1_ff * wy1_ff;
         p_ux2_ff  <= ux1_ff * ux1_ff;
         p_uy2_ff  <= uy1_ff * uy1_ff;
         p_wxdy_ff <= wx1_ff * dy1_ff;
         p_wydx_ff <= wy1_ff * dx1_ff;
         p_dxqy_ff <= dx1_ff * qy1_ff;
         p_dyqx_ff <= dy1_ff * qx1_ff;
         p_wxqy_ff <= wx1_ff * qy1_ff;
         p_wyqx_ff <= wy1_ff * qx1_ff;

         f3_ff <= f3_in;
      end
   end

   // squares are never negative, so their top bit can go
   always_comb begin
      f3_in            = '0;
      f3_in.op         = op2_ff;
      f3_in.dot        = $signed({p_wd_ff[sdc_pkg::ProdW-1], p_wd_ff})
                       + $signed({p_wd2_ff[sdc_pkg::ProdW-1], p_wd2_ff});
      f3_in.len2       = {1'b0, p_dx2_ff[sdc_pkg::ProdW-2:0]}
                       + {1'b0, p_dy2_ff[sdc_pkg::ProdW-2:0]};
      f3_in.norm_start = {1'b0, p_wx2_ff[sdc_pkg::ProdW-2:0]}
                       + {1'b0, p_wy2_ff[sdc_pkg::ProdW-2:0]};
      f3_in.norm_end   = {1'b0, p_ux2_ff[sdc_pkg::ProdW-2:0]}
                       + {1'b0, p_uy2_ff[sdc_pkg::ProdW-2:0]};
      f3_in.un         = $signed({p_wxdy_ff[sdc_pkg::ProdW-1], p_wxdy_ff})
                       - $signed({p_wydx_ff[sdc_pkg::ProdW-1], p_wydx_ff});
      f3_in.den        = $signed({p_dxqy_ff[sdc_pkg::ProdW-1], p_dxqy_ff})
                       - $signed({p_dyqx_ff[sdc_pkg::ProdW-1], p_dyqx_ff});
      f3_in.tn         = $signed({p_wxqy_ff[sdc_pkg::ProdW-1], p_wxqy_ff})
                       - $signed({p_wyqx_ff[sdc_pkg::ProdW-1], p_wyqx_ff});
   end

   assign out_valid = v3_ff;
   assign out_data  = f3_ff;

endmodule

### rtl/sdc_select.sv
module sdc_select (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  sdc_pkg::front_out_type in_data,
   output logic                   out_valid,
   output sdc_pkg::root_in_type   out_data
);

   // stage 4: case selection, crossing decision
   logic v4_ff;
   sdc_pkg::op_type op4_ff;
   logic sq4_in, sq4_ff, hit4_in, hit4_ff;
   logic [sdc_pkg::MagW-1:0] nl4_in, nl4_ff, cr4_in, cr4_ff;
   logic [sdc_pkg::MW-1:0] m4_in, m4_ff;
   logic signed [sdc_pkg::SumW-1:0] cr_abs, den_n, tn_n, un_n;

   // stage 5: partial products of the squared cross term
   logic v5_ff;
   sdc_pkg::op_type op5_ff;
   logic sq5_ff, hit5_ff;
   logic [sdc_pkg::MagW-1:0] nl5_ff;
   logic [sdc_pkg::MW-1:0] m5_ff;
   logic [2*sdc_pkg::HalfW-1:0] hh5_ff, hl5_ff, ll5_ff;

   // stage 6
   logic v6_ff;
   logic [sdc_pkg::CandW-1:0] sq_sum;
   sdc_pkg::root_in_type r6_in, r6_ff;

   always_comb begin
      cr_abs = in_data.un[sdc_pkg::SumW-1] ? -in_data.un : in_data.un;
      sq4_in = 1'b0;
      m4_in  = sdc_pkg::MW'(1);
      cr4_in = cr_abs[sdc_pkg::MagW-1:0];
      if ((in_data.len2 == '0) || in_data.dot[sdc_pkg::SumW-1]) begin
         nl4_in = in_data.norm_start;
      end else if (in_data.dot[sdc_pkg::MagW-1:0] > in_data.len2) begin
         nl4_in = in_data.norm_end;
      end else begin
         nl4_in = '0;
         sq4_in = 1'b1;
         m4_in  = in_data.len2;
      end
   end

   always_comb begin
      if (in_data.den[sdc_pkg::SumW-1]) begin
         den_n = -in_data.den;
         tn_n  = -in_data.tn;
         un_n  = -in_data.un;
      end else begin
         den_n = in_data.den;
         tn_n  = in_data.tn;
         un_n  = in_data.un;
      end
      hit4_in = (den_n != '0) && !tn_n[sdc_pkg::SumW-1] && (tn_n <= den_n)
              && !un_n[sdc_pkg::SumW-1] && (un_n <= den_n);
   end

   always_comb begin
      sq_sum = (sdc_pkg::CandW'(hh5_ff) << (2 * sdc_pkg::HalfW))
             + (sdc_pkg::CandW'(hl5_ff) << (sdc_pkg::HalfW + 1))
             + sdc_pkg::CandW'(ll5_ff);
      r6_in.op  = op5_ff;
      r6_in.hit = hit5_ff;
      r6_in.m   = m5_ff;
      r6_in.n   = sq5_ff ? sq_sum[sdc_pkg::NW-1:0] : sdc_pkg::NW'(nl5_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= in_valid;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         op4_ff  <= in_data.op;
         sq4_ff  <= sq4_in;
         hit4_ff <= hit4_in;
         nl4_ff  <= nl4_in;
         cr4_ff  <= cr4_in;
         m4_ff   <= m4_in;

         op5_ff  <= op4_ff;
         sq5_ff  <= sq4_ff;
         hit5_ff <= hit4_ff;
         nl5_ff  <= nl4_ff;
         m5_ff   <= m4_ff;
         hh5_ff  <= cr4_ff[sdc_pkg::MagW-1:sdc_pkg::HalfW] * cr4_ff[sdc_pkg::MagW-1:sdc_pkg::HalfW];
         hl5_ff  <= cr4_ff[sdc_pkg::MagW-1:sdc_pkg::HalfW] * cr4_ff[sdc_pkg::HalfW-1:0];
         ll5_ff  <= cr4_ff[sdc_pkg::HalfW-1:0] * cr4_ff[sdc_pkg::HalfW-1:0];

         r6_ff   <= r6_in;
      end
   end

   assign out_valid = v6_ff;
   assign out_data  = r6_ff;

endmodule

### rtl/sdc_root.sv
module sdc_root (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  sdc_pkg::root_in_type          in_data,
   output logic                          out_valid,
   output sdc_pkg::op_type               out_op,
   output logic                          out_hit,
   output logic [sdc_pkg::DistW-1:0]     out_root
);

   // largest d with d*d*m <= n, one bit per stage, msb first
   // p holds d*d*m and q holds d*m so each trial needs only shifts and adds
   logic                        v_ff   [0:sdc_pkg::RootSteps-1];
   sdc_pkg::op_type             op_ff  [0:sdc_pkg::RootSteps-1];
   logic                        hit_ff [0:sdc_pkg::RootSteps-1];
   logic [sdc_pkg::NW-1:0]      n_ff   [0:sdc_pkg::RootSteps-1];
   logic [sdc_pkg::MW-1:0]      m_ff   [0:sdc_pkg::RootSteps-1];
   logic [sdc_pkg::NW-1:0]      p_ff   [0:sdc_pkg::RootSteps-1];
   logic [sdc_pkg::QW-1:0]      q_ff   [0:sdc_pkg::RootSteps-1];
   logic [sdc_pkg::DistW-1:0]   d_ff   [0:sdc_pkg::RootSteps-1];

   for (genvar s = 0; s < sdc_pkg::RootSteps; s++) begin : g_step
      localparam int Bit = sdc_pkg::RootSteps - 1 - s;

      logic                      v_cur;
      sdc_pkg::op_type           op_cur;
      logic                      hit_cur;
      logic [sdc_pkg::NW-1:0]    n_cur, p_cur, p_in;
      logic [sdc_pkg::MW-1:0]    m_cur;
      logic [sdc_pkg::QW-1:0]    q_cur, q_in;
      logic [sdc_pkg::DistW-1:0] d_cur, d_in;
      logic [sdc_pkg::CandW-1:0] cand;
      logic                      take;

      if (s == 0) begin : g_first
         assign v_cur   = in_valid;
         assign op_cur  = in_data.op;
         assign hit_cur = in_data.hit;
         assign n_cur   = in_data.n;
         assign m_cur   = in_data.m;
         assign p_cur   = '0;
         assign q_cur   = '0;
         assign d_cur   = '0;
      end else begin : g_next
         assign v_cur   = v_ff[s-1];
         assign op_cur  = op_ff[s-1];
         assign hit_cur = hit_ff[s-1];
         assign n_cur   = n_ff[s-1];
         assign m_cur   = m_ff[s-1];
         assign p_cur   = p_ff[s-1];
         assign q_cur   = q_ff[s-1];
         assign d_cur   = d_ff[s-1];
      end

      always_comb begin
         cand = sdc_pkg::CandW'(p_cur)
              + (sdc_pkg::CandW'(q_cur) << (Bit + 1))
              + (sdc_pkg::CandW'(m_cur) << (2 * Bit));
         take = (cand <= sdc_pkg::CandW'(n_cur));
         p_in = take ? cand[sdc_pkg::NW-1:0] : p_cur;
         q_in = take ? q_cur + (sdc_pkg::QW'(m_cur) << Bit) : q_cur;
         d_in = d_cur;
         d_in[Bit] = take;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (adv) begin
            v_ff[s] <= v_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            op_ff[s]  <= op_cur;
            hit_ff[s] <= hit_cur;
            n_ff[s]   <= n_cur;
            m_ff[s]   <= m_cur;
            p_ff[s]   <= p_in;
            q_ff[s]   <= q_in;
            d_ff[s]   <= d_in;
         end
      end
   end

   assign out_valid = v_ff[sdc_pkg::RootSteps-1];
   assign out_op    = op_ff[sdc_pkg::RootSteps-1];
   assign out_hit   = hit_ff[sdc_pkg::RootSteps-1];
   assign out_root  = d_ff[sdc_pkg::RootSteps-1];

endmodule

### rtl/segment_distance_and_crossing.sv
// channel   direction  handshake              payload
// req_      in         req_valid / req_stall  req_opcode, req_a_x, req_a_y, req_b_x, req_b_y
// rsp_      out        rsp_valid / rsp_stall  rsp_distance, rsp_crosses
// csr_      in         csr_valid / csr_ready  csr_index, csr_data
//
// one transaction per cycle while rsp is not stalled; the path from req to rsp has three stages of
// differences, products and sums, three of case selection and squaring,
// 32 stages of the bit-at-a-time root search, one output register
// the whole pipeline moves as one, held only while rsp has a transaction stalled
// synchronous reset clears all valid bits and loads the default segment (0,0)-(65536,0)
module segment_distance_and_crossing (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_opcode,
   input  logic [sdc_pkg::CoordW-1:0]        req_a_x,
   input  logic [sdc_pkg::CoordW-1:0]        req_a_y,
   input  logic [sdc_pkg::CoordW-1:0]        req_b_x,
   input  logic [sdc_pkg::CoordW-1:0]        req_b_y,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sdc_pkg::DistW-1:0]         rsp_distance,
   output logic                              rsp_crosses,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sdc_pkg::CfgIdxW-1:0]       csr_index,
   input  logic [sdc_pkg::CoordW-1:0]        csr_data
);

   // segment end points
   logic [sdc_pkg::CoordW-1:0] start_x_ff, start_y_ff, end_x_ff, end_y_ff;

   // pipeline advance: everything moves unless the output is held
   logic adv;

   logic                   front_valid;
   sdc_pkg::front_out_type front_data;
   logic                   sel_valid;
   sdc_pkg::root_in_type   sel_data;
   logic                   root_valid;
   sdc_pkg::op_type        root_op;
   logic                   root_hit;
   logic [sdc_pkg::DistW-1:0] root_d;

   logic                      rsp_valid_ff;
   logic [sdc_pkg::DistW-1:0] rsp_distance_ff, rsp_distance_in;
   logic                      rsp_crosses_ff, rsp_crosses_in;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   // register writes, taken whenever offered
   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff <= '0;
         start_y_ff <= '0;
         end_x_ff   <= sdc_pkg::CoordW'(65536);
         end_y_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (sdc_pkg::cfg_index_type'(csr_index))
            sdc_pkg::CFG_START_X: start_x_ff <= csr_data;
            sdc_pkg::CFG_START_Y: start_y_ff <= csr_data;
            sdc_pkg::CFG_END_X:   end_x_ff   <= csr_data;
            sdc_pkg::CFG_END_Y:   end_y_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   sdc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_op     (sdc_pkg::op_type'(req_opcode)),
      .a_x       (req_a_x),
      .a_y       (req_a_y),
      .b_x       (req_b_x),
      .b_y       (req_b_y),
      .s_x       (start_x_ff),
      .s_y       (start_y_ff),
      .e_x       (end_x_ff),
      .e_y       (end_y_ff),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   sdc_select u_select (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (sel_valid),
      .out_data  (sel_data)
   );

   sdc_root u_root (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sel_valid),
      .in_data   (sel_data),
      .out_valid (root_valid),
      .out_op    (root_op),
      .out_hit   (root_hit),
      .out_root  (root_d)
   );

   // each query fills only its own field, the other reads zero
   always_comb begin
      if (root_op == sdc_pkg::OP_CROSSING) begin
         rsp_distance_in = '0;
         rsp_crosses_in  = root_hit;
      end else begin
         rsp_distance_in = root_d;
         rsp_crosses_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= root_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_distance_ff <= rsp_distance_in;
         rsp_crosses_ff  <= rsp_crosses_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_distance_ff;
   assign rsp_crosses  = rsp_crosses_ff;

   // a crossing transaction never carries a distance
   a_cross_no_dist : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_crosses_ff |-> rsp_distance_ff == '0)
      else $error("crossing result with non-zero distance");

   // a held output freezes the last root stage too
   a_hold_root : assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(root_valid) && $stable(root_d))
      else $error("root pipeline moved while output held");

   // reset empties the output
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("output valid after reset");

endmodule
